[rtl/programme_type_fig_parser_core_macros.svh]
// assertion macros shared by the programme type parser modules
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef PROGRAMME_TYPE_FIG_PARSER_CORE_MACROS_SVH
`define PROGRAMME_TYPE_FIG_PARSER_CORE_MACROS_SVH

// plain property check, off while in reset
`define PTFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// next-cycle implication, off while in reset
`define PTFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ptfp_pkg.sv]
// shared types and constants of the programme type record parser
// no dependencies
package ptfp_pkg;

	// seen service id store
	localparam int SEEN_DEPTH = 64;
	localparam int SEEN_IDX_W = $clog2(SEEN_DEPTH);
	localparam int SEEN_CNT_W = $clog2(SEEN_DEPTH + 1);

	// error mask bit positions
	localparam int ERR_FLAGS_RFA = 0;
	localparam int ERR_INT_RFA   = 1;
	localparam int ERR_INT_RFU   = 2;
	localparam int ERR_COMP_RFA  = 3;
	localparam int ERR_COMP_RFU  = 4;
	localparam int ERR_INT_MISS  = 5;
	localparam int ERR_COMP_MISS = 6;
	localparam int ERR_STORE_OVF = 7;

	// one input byte with its record markers
	typedef struct packed {
		logic [7:0] data_byte;
		logic       record_start;
		logic [4:0] record_length;
	} item_t;

	// one decoded entry, service_id in the lowest bits
	typedef struct packed {
		logic       repeat_seen;
		logic [7:0] error_mask;
		logic       complementary_present;
		logic [4:0] complementary_code;
		logic       international_present;
		logic [4:0] international_code;
		logic [7:0] language_code;
		logic       language_present;
		logic       secondary_flag;
		logic       static_flag;
		logic [15:0] service_id;
	} result_t;

	// lookup/insert request to the seen store
	typedef struct packed {
		logic        check;
		logic [15:0] id;
	} seen_req_t;

	// seen store answer, valid in the cycle of the request
	typedef struct packed {
		logic hit;
		logic full;
	} seen_rsp_t;

endpackage

[rtl/ptfp_seen_store.sv]
// store of service ids seen since the last repeat, filled in order
// depends on ptfp_pkg and the parser assertion macros
`include "programme_type_fig_parser_core_macros.svh"

module ptfp_seen_store (
	input  logic                clk,
	input  logic                arst_n,
	input  ptfp_pkg::seen_req_t req,
	output ptfp_pkg::seen_rsp_t rsp
);

	localparam int IdxW = ptfp_pkg::SEEN_IDX_W;
	localparam int CntW = ptfp_pkg::SEEN_CNT_W;

	logic [15:0]     ids_q [ptfp_pkg::SEEN_DEPTH];
	logic [CntW-1:0] fill_q;
	logic            hit;
	logic            full;

	// valid entries always form a prefix, so a fill count stands for the valid bits
	always_comb begin
		hit = 1'b0;
		for (int k = 0; k < ptfp_pkg::SEEN_DEPTH; k++) begin
			if ((CntW'(k) < fill_q) && (ids_q[k] == req.id)) begin
				hit = 1'b1;
			end
		end
	end

	assign full = (fill_q == CntW'(ptfp_pkg::SEEN_DEPTH));
	assign rsp.hit  = hit;
	assign rsp.full = full && !hit;

	// fill count: restart on a repeat, grow while room is left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (req.check) begin
			if (hit) begin
				fill_q <= CntW'(1);
			end else if (!full) begin
				fill_q <= fill_q + CntW'(1);
			end
		end
	end

	// id storage, written at the first free slot, or at slot 0 on a repeat
	always_ff @(posedge clk) begin
		if (req.check) begin
			if (hit) begin
				ids_q[0] <= req.id;
			end else if (!full) begin
				ids_q[fill_q[IdxW-1:0]] <= req.id;
			end
		end
	end

	`PTFP_ASSERT(a_fill_bound, fill_q <= CntW'(ptfp_pkg::SEEN_DEPTH), "seen store overfilled")
	`PTFP_ASSERT_NEXT(a_hit_restart, req.check && hit, fill_q == CntW'(1), "repeat did not restart store")
	`PTFP_ASSERT_NEXT(a_insert_grows, req.check && !hit && !full,
		fill_q == $past(fill_q) + CntW'(1), "new id not inserted")

endmodule

[rtl/ptfp_entry_parser.sv]
// byte-wise parser of programme type entries with its record state
// depends on ptfp_pkg and the parser assertion macros
`include "programme_type_fig_parser_core_macros.svh"

module ptfp_entry_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  ptfp_pkg::item_t     item,
	input  ptfp_pkg::seen_rsp_t seen_rsp,
	output ptfp_pkg::seen_req_t seen_req,
	output logic                res_valid,
	output ptfp_pkg::result_t   res
);

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_SIDLO = 3'd1;
	localparam logic [2:0] PH_FLAGS = 3'd2;
	localparam logic [2:0] PH_LANG  = 3'd3;
	localparam logic [2:0] PH_INT   = 3'd4;
	localparam logic [2:0] PH_COMP  = 3'd5;

	logic [4:0]  pos_q, len_q;
	logic [2:0]  phase_q;
	logic [15:0] sid_q;
	logic [3:0]  flg_q;
	logic [7:0]  lang_q;
	logic [4:0]  intc_q, compc_q;
	logic        intp_q, compp_q;
	logic [7:0]  err_q;
	logic        rep_q;

	logic [2:0]  phase_n;
	logic [15:0] sid_n;
	logic [3:0]  flg_n;
	logic [7:0]  lang_n;
	logic [4:0]  intc_n, compc_n;
	logic        intp_n, compp_n;
	logic [7:0]  err_n;
	logic        rep_n;
	logic        active, last, done;
	logic [7:0]  b;

	assign b      = item.data_byte;
	assign active = !item.record_start && (pos_q < len_q);
	assign last   = ({1'b0, pos_q} + 6'd1) == {1'b0, len_q};

	// service id completes on its second byte
	assign seen_req.check = step && active && (phase_q == PH_SIDLO);
	assign seen_req.id    = {sid_q[15:8], b};

	// next entry state for one byte inside the record
	always_comb begin
		phase_n = phase_q;
		sid_n   = sid_q;
		flg_n   = flg_q;
		lang_n  = lang_q;
		intc_n  = intc_q;
		compc_n = compc_q;
		intp_n  = intp_q;
		compp_n = compp_q;
		err_n   = err_q;
		rep_n   = rep_q;
		done    = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (({1'b0, pos_q} + 6'd3) < {1'b0, len_q}) begin
					sid_n   = {b, 8'h00};
					flg_n   = '0;
					lang_n  = '0;
					intc_n  = '0;
					compc_n = '0;
					intp_n  = 1'b0;
					compp_n = 1'b0;
					err_n   = '0;
					rep_n   = 1'b0;
					phase_n = PH_SIDLO;
				end
			end
			PH_SIDLO: begin
				sid_n[7:0] = b;
				rep_n      = seen_rsp.hit;
				if (seen_rsp.full) begin
					err_n[ptfp_pkg::ERR_STORE_OVF] = 1'b1;
				end
				phase_n = PH_FLAGS;
			end
			PH_FLAGS: begin
				flg_n = b[7:4];
				if (b[3:0] != 4'h0) begin
					err_n[ptfp_pkg::ERR_FLAGS_RFA] = 1'b1;
				end
				phase_n = b[5] ? PH_LANG : PH_INT;
			end
			PH_LANG: begin
				lang_n  = b;
				phase_n = PH_INT;
			end
			PH_INT: begin
				if (b[7:6] != 2'b00) begin
					err_n[ptfp_pkg::ERR_INT_RFA] = 1'b1;
				end
				if (b[5]) begin
					err_n[ptfp_pkg::ERR_INT_RFU] = 1'b1;
				end
				intc_n = b[4:0];
				intp_n = 1'b1;
				if (flg_q[0]) begin
					phase_n = PH_COMP;
				end else begin
					done = 1'b1;
				end
			end
			default: begin
				if (b[7:6] != 2'b00) begin
					err_n[ptfp_pkg::ERR_COMP_RFA] = 1'b1;
				end
				if (b[5]) begin
					err_n[ptfp_pkg::ERR_COMP_RFU] = 1'b1;
				end
				compc_n = b[4:0];
				compp_n = 1'b1;
				done    = 1'b1;
			end
		endcase
		// entry cut off by the record's last byte
		if (!done && last && (phase_n != PH_IDLE)) begin
			if (phase_n <= PH_INT) begin
				err_n[ptfp_pkg::ERR_INT_MISS] = 1'b1;
			end
			if (flg_n[0]) begin
				err_n[ptfp_pkg::ERR_COMP_MISS] = 1'b1;
			end
			done = 1'b1;
		end
		if (done) begin
			phase_n = PH_IDLE;
		end
	end

	// result fields straight from the updated entry
	assign res_valid                 = step && active && done;
	assign res.service_id            = sid_n;
	assign res.static_flag           = flg_n[3];
	assign res.secondary_flag        = flg_n[2];
	assign res.language_present      = flg_n[1];
	assign res.language_code         = lang_n;
	assign res.international_code    = intc_n;
	assign res.international_present = intp_n;
	assign res.complementary_code    = compc_n;
	assign res.complementary_present = compp_n;
	assign res.error_mask            = err_n;
	assign res.repeat_seen           = rep_q & 1'b0 | rep_n;

	// record and entry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			len_q   <= '0;
			phase_q <= PH_IDLE;
			sid_q   <= '0;
			flg_q   <= '0;
			lang_q  <= '0;
			intc_q  <= '0;
			compc_q <= '0;
			intp_q  <= 1'b0;
			compp_q <= 1'b0;
			err_q   <= '0;
			rep_q   <= 1'b0;
		end else if (step) begin
			if (item.record_start) begin
				len_q   <= item.record_length;
				pos_q   <= 5'd1;
				phase_q <= PH_IDLE;
				sid_q   <= '0;
				flg_q   <= '0;
				lang_q  <= '0;
				intc_q  <= '0;
				compc_q <= '0;
				intp_q  <= 1'b0;
				compp_q <= 1'b0;
				err_q   <= '0;
				rep_q   <= 1'b0;
			end else if (active) begin
				pos_q   <= (pos_q == 5'd31) ? 5'd31 : pos_q + 5'd1;
				phase_q <= phase_n;
				sid_q   <= sid_n;
				flg_q   <= flg_n;
				lang_q  <= lang_n;
				intc_q  <= intc_n;
				compc_q <= compc_n;
				intp_q  <= intp_n;
				compp_q <= compp_n;
				err_q   <= err_n;
				rep_q   <= rep_n;
			end
		end
	end

	`PTFP_ASSERT(a_phase_legal, phase_q <= PH_COMP, "entry phase out of range")
	`PTFP_ASSERT_NEXT(a_done_idle, res_valid, phase_q == PH_IDLE, "phase not idle after result")
	`PTFP_ASSERT_NEXT(a_start_pos, step && item.record_start, pos_q == 5'd1,
		"record start did not rewind position")

endmodule

[rtl/programme_type_fig_parser_core.sv]
// an entry's last byte waits in the input register, then its result enters the result register
// throughput: one byte per cycle; a result held by the sink stalls the parse stage and ready
// drops once the input register also holds a byte
// reset: arst_n clears both valids, record position, length, entry state and the seen fill count
// top level of the programme type record parser; depends on ptfp_pkg,
// ptfp_entry_parser and ptfp_seen_store
module programme_type_fig_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // data_byte[7:0], record_length[12:8], zero[15:13]
	input  logic        s_axis_tuser,  // record_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// service_id[15:0], static_flag[16], secondary_flag[17], language_present[18],
	// language_code[26:19], international_code[31:27], international_present[32],
	// complementary_code[37:33], complementary_present[38], error_mask[46:39],
	// repeat_seen[47]
	output logic [47:0] m_axis_tdata
);

	logic                valid_s1;
	ptfp_pkg::item_t     item_s1;
	logic                advance;
	logic                par_valid;
	ptfp_pkg::result_t   par_res;
	ptfp_pkg::result_t   res_q;
	logic                out_valid_q;
	ptfp_pkg::seen_req_t seen_req;
	ptfp_pkg::seen_rsp_t seen_rsp;

	// parse stage moves when the output register is free or being drained
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.data_byte     <= s_axis_tdata[7:0];
			item_s1.record_length <= s_axis_tdata[12:8];
			item_s1.record_start  <= s_axis_tuser;
		end
	end

	ptfp_entry_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.seen_rsp  (seen_rsp),
		.seen_req  (seen_req),
		.res_valid (par_valid),
		.res       (par_res)
	);

	ptfp_seen_store u_seen (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (seen_req),
		.rsp    (seen_rsp)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= advance && par_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && par_valid) begin
			res_q <= par_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;

endmodule

[sim/programme_type_fig_parser_core_test.sv]
// self-checking testbench for the programme type record parser top level
// needs ptfp_pkg and the parser rtl; predicts each decoded entry and compares
`timescale 1ns / 100ps

module programme_type_fig_parser_core_test;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASE_ITEMS = 150;

	// where the predicted parser stands inside an entry
	typedef enum logic [2:0] {
		ENTRY_IDLE,
		ENTRY_SID_LO,
		ENTRY_FLAGS,
		ENTRY_LANG,
		ENTRY_INT,
		ENTRY_COMP
	} entry_phase_t;

	// predicts decoded entries from accepted bytes and checks the ones that come out
	class entry_scoreboard;
		ptfp_pkg::result_t expected_entries[$];
		int unsigned       failures;
		logic [4:0]        rec_len;
		logic [4:0]        rec_pos;
		entry_phase_t      phase;
		ptfp_pkg::result_t cur;
		bit                comp_follows;
		logic [15:0]       id_store[ptfp_pkg::SEEN_DEPTH];
		bit                id_valid[ptfp_pkg::SEEN_DEPTH];

		function new();
			failures = 0;
			rec_len = '0;
			rec_pos = '0;
			phase = ENTRY_IDLE;
			cur = '0;
			comp_follows = 1'b0;
			foreach (id_valid[k]) id_valid[k] = 1'b0;
		endfunction

		function int unsigned ids_stored();
			int unsigned n;
			n = 0;
			foreach (id_valid[k]) if (id_valid[k]) n++;
			return n;
		endfunction

		// repeat lookup, store clear on a hit, then insert into the first free slot
		function void lookup_id(logic [15:0] id);
			bit hit;
			bit placed;
			hit = 1'b0;
			placed = 1'b0;
			foreach (id_valid[k]) if (id_valid[k] && id_store[k] == id) hit = 1'b1;
			if (hit) foreach (id_valid[k]) id_valid[k] = 1'b0;
			cur.repeat_seen = hit;
			foreach (id_valid[k]) begin
				if (!placed && !id_valid[k]) begin
					id_valid[k] = 1'b1;
					id_store[k] = id;
					placed = 1'b1;
				end
			end
			if (!placed) cur.error_mask[ptfp_pkg::ERR_STORE_OVF] = 1'b1;
		endfunction

		// one accepted input transfer
		function void note_byte(logic [7:0] b, logic start, logic [4:0] len);
			int unsigned p;
			bit finished;
			bit last_byte;
			finished = 1'b0;
			if (start) begin
				rec_len = len;
				rec_pos = 5'd1;
				phase = ENTRY_IDLE;
				cur = '0;
				comp_follows = 1'b0;
				return;
			end
			if (rec_pos >= rec_len) return;
			p = rec_pos;
			last_byte = (p + 1 == rec_len);
			rec_pos = (p < 31) ? 5'(p + 1) : 5'd31;

			case (phase)
				ENTRY_IDLE: begin
					// an entry only starts with at least four bytes left
					if (p + 3 < rec_len) begin
						cur = '0;
						comp_follows = 1'b0;
						cur.service_id[15:8] = b;
						phase = ENTRY_SID_LO;
					end
				end
				ENTRY_SID_LO: begin
					cur.service_id[7:0] = b;
					lookup_id(cur.service_id);
					phase = ENTRY_FLAGS;
				end
				ENTRY_FLAGS: begin
					cur.static_flag = b[7];
					cur.secondary_flag = b[6];
					cur.language_present = b[5];
					comp_follows = b[4];
					if (b[3:0] != 4'h0) cur.error_mask[ptfp_pkg::ERR_FLAGS_RFA] = 1'b1;
					phase = b[5] ? ENTRY_LANG : ENTRY_INT;
				end
				ENTRY_LANG: begin
					cur.language_code = b;
					phase = ENTRY_INT;
				end
				ENTRY_INT: begin
					if (b[7:6] != 2'b00) cur.error_mask[ptfp_pkg::ERR_INT_RFA] = 1'b1;
					if (b[5]) cur.error_mask[ptfp_pkg::ERR_INT_RFU] = 1'b1;
					cur.international_code = b[4:0];
					cur.international_present = 1'b1;
					if (comp_follows) phase = ENTRY_COMP;
					else finished = 1'b1;
				end
				default: begin
					if (b[7:6] != 2'b00) cur.error_mask[ptfp_pkg::ERR_COMP_RFA] = 1'b1;
					if (b[5]) cur.error_mask[ptfp_pkg::ERR_COMP_RFU] = 1'b1;
					cur.complementary_code = b[4:0];
					cur.complementary_present = 1'b1;
					finished = 1'b1;
				end
			endcase

			// entry cut off by the end of the record
			if (!finished && last_byte && phase != ENTRY_IDLE) begin
				if (phase != ENTRY_COMP) cur.error_mask[ptfp_pkg::ERR_INT_MISS] = 1'b1;
				if (comp_follows) cur.error_mask[ptfp_pkg::ERR_COMP_MISS] = 1'b1;
				finished = 1'b1;
			end
			if (finished) begin
				expected_entries = {expected_entries, cur};
				phase = ENTRY_IDLE;
			end
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				failures++;
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		// one accepted output transfer
		function void check_entry(logic [47:0] raw);
			ptfp_pkg::result_t got;
			ptfp_pkg::result_t want;
			got = ptfp_pkg::result_t'(raw);
			if (expected_entries.size() == 0) begin
				failures++;
				$display("%0t: entry expected none actual %h", $time, raw);
				return;
			end
			want = expected_entries.pop_front();
			compare_field("service_id", want.service_id, got.service_id);
			compare_field("static_flag", want.static_flag, got.static_flag);
			compare_field("secondary_flag", want.secondary_flag, got.secondary_flag);
			compare_field("language_present", want.language_present, got.language_present);
			compare_field("language_code", want.language_code, got.language_code);
			compare_field("international_code", want.international_code,
				got.international_code);
			compare_field("international_present", want.international_present,
				got.international_present);
			compare_field("complementary_code", want.complementary_code,
				got.complementary_code);
			compare_field("complementary_present", want.complementary_present,
				got.complementary_present);
			compare_field("error_mask", want.error_mask, got.error_mask);
			compare_field("repeat_seen", want.repeat_seen, got.repeat_seen);
		endfunction

		function void flag_leftovers();
			ptfp_pkg::result_t want;
			while (expected_entries.size() != 0) begin
				want = expected_entries.pop_front();
				failures++;
				$display("%0t: entry expected %h actual none", $time, want);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // data_byte[7:0], record_length[12:8], zero[15:13]
	logic        s_axis_tuser = 1'b0; // record_start
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;       // result_t layout, service_id lowest

	entry_scoreboard sb;
	int unsigned     src_idle_pct = 0;
	int unsigned     sink_stall_pct = 0;
	int unsigned     sink_hold = 0;
	int unsigned     cycle_count = 0;
	int unsigned     items_sent = 0;
	logic [15:0]     recent_ids[$];

	programme_type_fig_parser_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("programme_type_fig_parser_core verification failed");
			$finish;
		end
	end

	// result side: check transfers, stall at random or for a long hold
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_entry(m_axis_tdata);
			if (sink_hold != 0) begin
				sink_hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// one byte transfer, with random idle cycles ahead of it
	task automatic send_item(input logic [7:0] b, input logic start, input logic [4:0] len);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, len, b};
		s_axis_tuser <= start;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_byte(b, start, len);
	endtask

	// fresh ids mostly; recent ones again to provoke repeats, more so once the store is full
	function automatic logic [15:0] pick_service_id(int unsigned reuse_pct);
		logic [15:0] id;
		if (recent_ids.size() != 0 && ($urandom_range(99) < reuse_pct ||
			(sb.ids_stored() == ptfp_pkg::SEEN_DEPTH && $urandom_range(99) < 30)))
			id = recent_ids[$urandom_range(recent_ids.size() - 1)];
		else
			id = 16'($urandom);
		recent_ids = {recent_ids, id};
		if (recent_ids.size() > 20) void'(recent_ids.pop_front());
		return id;
	endfunction

	function automatic logic [7:0] code_byte();
		if ($urandom_range(4) == 0) return 8'($urandom);
		return {3'b000, 5'($urandom)};
	endfunction

	// one record of well-formed entries, sometimes abandoned early or followed by junk
	task automatic send_record(input int unsigned reuse_pct);
		logic [7:0]  body[$];
		logic [4:0]  len;
		logic [7:0]  flags;
		logic [15:0] sid;
		int unsigned stop_at;
		if ($urandom_range(9) == 0) len = 5'($urandom_range(4));
		else len = 5'($urandom_range(31, 5));
		while (body.size() + 1 < len) begin
			sid = pick_service_id(reuse_pct);
			flags[7:6] = 2'($urandom);
			flags[5] = ($urandom_range(99) < 30);
			flags[4] = ($urandom_range(99) < 30);
			flags[3:0] = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 1)) : 4'h0;
			body = {body, sid[15:8], sid[7:0], flags};
			if (flags[5]) body = {body, 8'($urandom)};
			body = {body, code_byte()};
			if (flags[4]) body = {body, code_byte()};
		end
		stop_at = (len == 0) ? 0 : len - 1;
		if (len > 1 && $urandom_range(11) == 0) stop_at = $urandom_range(len - 2);
		send_item(8'($urandom), 1'b1, len);
		items_sent++;
		for (int i = 0; i < stop_at; i++) begin
			send_item(body[i], 1'b0, 5'($urandom));
			items_sent++;
		end
		// bytes past the end of the record
		if ($urandom_range(11) == 0) begin
			repeat ($urandom_range(3, 1)) begin
				send_item(8'($urandom), 1'b0, 5'($urandom));
				items_sent++;
			end
		end
	endtask

	// hold the input off until every predicted entry has come out
	task automatic drain_entries();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_entries.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// stimulus
	initial begin
		int unsigned phase_end;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes before any record are ignored
		send_item(8'hFF, 1'b0, 5'd31);
		send_item(8'h00, 1'b0, 5'd0);
		// shortest record with an entry: language taken, codes cut off
		send_item(8'h00, 1'b1, 5'd5);
		send_item(8'hFF, 1'b0, 5'd31);
		send_item(8'hFF, 1'b0, 5'd0);
		send_item(8'hFF, 1'b0, 5'd31);
		send_item(8'h00, 1'b0, 5'd0);
		// three full entries, every reserved bit set somewhere, the last id repeats
		send_item(8'hFF, 1'b1, 5'd17);
		send_item(8'h00, 1'b0, 5'd0);
		send_item(8'h00, 1'b0, 5'd0);
		send_item(8'h00, 1'b0, 5'd0);
		send_item(8'hFF, 1'b0, 5'd0);
		send_item(8'h12, 1'b0, 5'd0);
		send_item(8'h34, 1'b0, 5'd0);
		send_item(8'hF0, 1'b0, 5'd0);
		send_item(8'hAA, 1'b0, 5'd0);
		send_item(8'h1F, 1'b0, 5'd0);
		send_item(8'hE0, 1'b0, 5'd0);
		send_item(8'h00, 1'b0, 5'd0);
		send_item(8'h00, 1'b0, 5'd0);
		send_item(8'h1F, 1'b0, 5'd0);
		send_item(8'h40, 1'b0, 5'd0);
		send_item(8'hFF, 1'b0, 5'd0);
		// record's last byte, too late to start an entry
		send_item(8'h5A, 1'b0, 5'd31);
		items_sent = items_sent + 24;
		drain_entries();

		// random records under different idle patterns
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
					sink_hold = 300;
				end
				1: begin
					src_idle_pct = 82;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 82;
				end
				default: begin
					src_idle_pct = 10;
					sink_stall_pct = 10;
				end
			endcase
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) send_record((ph == 3) ? 20 : 0);
			drain_entries();
		end

		sink_stall_pct = 0;
		repeat (20) @(posedge clk);
		sb.flag_leftovers();
		if (sb.failures == 0)
			$display("programme_type_fig_parser_core verification clean");
		else
			$display("programme_type_fig_parser_core verification failed");
		$finish;
	end

endmodule

[programme_type_fig_parser_core.f]
+incdir+rtl
rtl/ptfp_pkg.sv
rtl/ptfp_seen_store.sv
rtl/ptfp_entry_parser.sv
rtl/programme_type_fig_parser_core.sv
sim/programme_type_fig_parser_core_test.sv
